>>> sv/tkst_pkg.sv
// Package for the top-k score tracker: table size, derived widths,
// item payload structs and the command/status structs between controller and datapath.
// Depends on nothing; every other file of the block imports it.
package tkst_pkg;

  // table geometry
  localparam int unsigned TABLE_SLOTS = 10;
  localparam int unsigned SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned CNT_W       = $clog2(TABLE_SLOTS + 1);

  // fixed field widths
  localparam int unsigned VAR_W   = 10;
  localparam int unsigned SCORE_W = 16;
  localparam int unsigned NIB_W   = 4;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_CLEAR  = 1'b1
  } mode_e;

  // input item
  typedef struct packed {
    mode_e              mode;
    logic [VAR_W-1:0]   var_index;
    logic               descending;
    logic [SCORE_W-1:0] score;
  } in_item_t;

  // result item
  typedef struct packed {
    logic               accepted;
    logic [NIB_W-1:0]   slot_written;
    logic [NIB_W-1:0]   held_count;
    logic [VAR_W-1:0]   best_var;
    logic               best_descending;
    logic [SCORE_W-1:0] best_score;
  } out_item_t;

  // one table entry
  typedef struct packed {
    logic [VAR_W-1:0]   var_index;
    logic               descending;
    logic [SCORE_W-1:0] score;
  } slot_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clear;
    logic fill_write;
    logic scan_start;
    logic replace;
    logic emit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_clear;
    logic is_full;
    logic scan_done;
  } dp_status_t;

endpackage

>>> sv/top_k_score_tracker_unit.sv
// Top level of the top-k score tracker: joins controller and datapath.
// Depends on tkst_pkg, tkst_ctrl and tkst_datapath.
//
// Keeps the TABLE_SLOTS best candidates (10 slots) and returns one result item for every
// input item. One item is worked on at a time. A clear, or an insert while the table is
// not full, goes from decide straight to done. An insert into a full table first scans
// the slot memory for the lowest entry, one read per cycle through its registered read
// port, then replaces it if the new score is higher. The best entry is kept in registers
// and updated when a write takes the lead, so it costs no scan. A finished result waits in
// an output register while the next item is accepted and worked on.
module top_k_score_tracker_unit
  import tkst_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer
  tkst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // table and result datapath
  tkst_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_item_o (out_item_o)
  );

endmodule

>>> sv/tkst_ctrl.sv
// Controller of the top-k score tracker: sequences load, clear, fill or minimum scan,
// replacement and result hand-off, and owns the input stall and output valid.
// Depends on tkst_pkg.
module tkst_ctrl
  import tkst_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_UPDATE,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // result register can take a new item
  assign out_free = !out_valid_q || !out_stall_i;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (status_i.is_clear) begin
          cmd_o.clear = 1'b1;
          state_d     = ST_DONE;
        end else if (!status_i.is_full) begin
          cmd_o.fill_write = 1'b1;
          state_d          = ST_DONE;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.scan_done) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.replace = 1'b1;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output valid follows the result register
  always_comb begin
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> sv/tkst_datapath.sv
// Datapath of the top-k score tracker: slot memory, fill count, minimum scan,
// running best entry and the result register.
// Depends on tkst_pkg; driven by commands from tkst_ctrl.
module tkst_datapath
  import tkst_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_item_t   in_item_i,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t status_o,
  output out_item_t  out_item_o
);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(TABLE_SLOTS);

  slot_t              mem [TABLE_SLOTS];
  slot_t              rd_data_q;
  logic               wr_en;
  logic [SLOT_W-1:0]  wr_addr;
  slot_t              wr_data;

  in_item_t           item_q;
  logic [CNT_W-1:0]   fill_q;

  logic               scan_active_q;
  logic [SLOT_W-1:0]  scan_addr_q;
  logic               rd_vld_q;
  logic [SLOT_W-1:0]  rd_idx_q;
  logic [SCORE_W-1:0] min_score_q;
  logic [SLOT_W-1:0]  min_slot_q;

  slot_t              best_q;
  logic [SLOT_W-1:0]  best_slot_q;
  logic               acc_q;
  logic [SLOT_W-1:0]  slot_out_q;
  out_item_t          out_q;

  logic               win;
  logic               fill_takes_best;
  logic               repl_takes_best;

  // candidate as a table entry
  assign wr_data = '{var_index: item_q.var_index, descending: item_q.descending,
                     score: item_q.score};

  // replacement beats the minimum only when strictly greater
  assign win = (item_q.score > min_score_q);

  // new entry sits above all others, so ties keep the old best
  assign fill_takes_best = (fill_q == '0) || (item_q.score > best_q.score);

  // replacing the best itself means every entry was equal, so the new one leads
  assign repl_takes_best = (min_slot_q == best_slot_q) || (item_q.score > best_q.score) ||
                           ((item_q.score == best_q.score) && (min_slot_q < best_slot_q));

  // memory write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = min_slot_q;
    if (cmd_i.fill_write) begin
      wr_en   = 1'b1;
      wr_addr = fill_q[SLOT_W-1:0];
    end else if (cmd_i.replace && win) begin
      wr_en   = 1'b1;
      wr_addr = min_slot_q;
    end
  end

  // slot memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[scan_addr_q];
  end

  // scan sequencer, one read a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_active_q <= 1'b0;
      scan_addr_q   <= '0;
      rd_vld_q      <= 1'b0;
      rd_idx_q      <= '0;
    end else begin
      rd_vld_q <= scan_active_q;
      rd_idx_q <= scan_addr_q;
      if (cmd_i.scan_start) begin
        scan_active_q <= 1'b1;
        scan_addr_q   <= '0;
      end else if (scan_active_q) begin
        if (scan_addr_q == LAST_SLOT) begin
          scan_active_q <= 1'b0;
        end else begin
          scan_addr_q <= scan_addr_q + 1'b1;
        end
      end
    end
  end

  // running minimum, lowest slot wins ties
  always_ff @(posedge clk_i) begin
    if (rd_vld_q && ((rd_idx_q == '0) || (rd_data_q.score < min_score_q))) begin
      min_score_q <= rd_data_q.score;
      min_slot_q  <= rd_idx_q;
    end
  end

  // fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cmd_i.clear) begin
      fill_q <= '0;
    end else if (cmd_i.fill_write) begin
      fill_q <= fill_q + 1'b1;
    end
  end

  // item capture, best entry, per-item result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_item_i;
    end
    if (cmd_i.clear) begin
      acc_q      <= 1'b0;
      slot_out_q <= '0;
    end
    if (cmd_i.fill_write) begin
      acc_q      <= 1'b1;
      slot_out_q <= fill_q[SLOT_W-1:0];
      if (fill_takes_best) begin
        best_q      <= wr_data;
        best_slot_q <= fill_q[SLOT_W-1:0];
      end
    end
    if (cmd_i.replace) begin
      acc_q      <= win;
      slot_out_q <= win ? min_slot_q : '0;
      if (win && repl_takes_best) begin
        best_q      <= wr_data;
        best_slot_q <= min_slot_q;
      end
    end
    if (cmd_i.emit) begin
      out_q.accepted        <= acc_q;
      out_q.slot_written    <= NIB_W'(slot_out_q);
      out_q.held_count      <= NIB_W'(fill_q);
      out_q.best_var        <= (fill_q != '0) ? best_q.var_index : '0;
      out_q.best_descending <= (fill_q != '0) ? best_q.descending : 1'b0;
      out_q.best_score      <= (fill_q != '0) ? best_q.score : '0;
    end
  end

  // status to the controller
  assign status_o.is_clear  = (item_q.mode == MODE_CLEAR);
  assign status_o.is_full   = (fill_q == FULL_CNT);
  assign status_o.scan_done = rd_vld_q && (rd_idx_q == LAST_SLOT);

  assign out_item_o = out_q;

  // checks
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FULL_CNT)
    else $error("fill count above table size");

  a_wr_addr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (wr_addr <= LAST_SLOT))
    else $error("write beyond last slot");

  a_repl_after_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.replace |-> (!scan_active_q && !rd_vld_q))
    else $error("replace while minimum scan still running");

  a_wr_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> (fill_q != '0))
    else $error("table empty right after a write");

endmodule
